### hdl/rlwq_pkg.sv
// ----------------------------------------------------------------------------
// rlwq_pkg
// Shared constants, codes and widths of the recursive lock with wait queue.
// ----------------------------------------------------------------------------
package rlwq_pkg;

	localparam int WAIT_DEPTH = 16;
	localparam int ID_BITS    = 8;
	localparam int NEST_MAX   = 255;

	localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
	localparam int NEST_W = $clog2(NEST_MAX + 1);

	localparam int OP_W     = 2;
	localparam int REQ_W    = 8;
	localparam int STATUS_W = 3;
	localparam int OUT_ID_W = 8;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [OP_W-1:0] OP_OBTAIN  = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_ATTEMPT = 2'd2;

	localparam logic [ID_BITS-1:0] ANON_ID = {ID_BITS{1'b1}};
	localparam logic [ID_BITS-1:0] NO_ID   = '0;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_REFUSED  = 3'd2,
		ST_HELD     = 3'd3,
		ST_HANDED   = 3'd4,
		ST_FREED    = 3'd5,
		ST_CORRUPT  = 3'd6,
		ST_OVERFLOW = 3'd7
	} status_t;

endpackage

### hdl/rlwq_ram.sv
// ----------------------------------------------------------------------------
// rlwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlwq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/recursive_lock_with_wait_queue.sv
// ----------------------------------------------------------------------------
// recursive_lock_with_wait_queue
// Recursive lock with a first-in-first-out queue of waiting requesters.
// ----------------------------------------------------------------------------
// A request is captured into op_s1 and who_s1; its result is registered into
//   out_data_q once the output is free, and only then is a new one taken. The
//   waiter queue RAM read and the read-modify-write of the lock state allow one
//   request in work; a result held by m_axis_tready low holds it and stalls input.
// Reset: arst_n clears the lock to free, the queue to empty and both channels
//   to idle; the queue RAM has no reset value; its data is used only once written.
module recursive_lock_with_wait_queue
	import rlwq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // op[1:0], requester[9:2], zero
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[2:0], woken_id[10:3], holder[18:11], zero
);

	logic [ID_BITS-1:0] owner_q;
	logic [NEST_W-1:0]  nest_q;
	logic [PTR_W-1:0]   head_q;
	logic [FILL_W-1:0]  fill_q;

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [ID_BITS-1:0] who_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic               in_fire;
	logic               done_s1;
	logic [ID_BITS-1:0] who_in;
	logic [ID_BITS-1:0] head_id;

	logic               ram_we;
	logic [PTR_W-1:0]   tail_ptr;
	logic [PTR_W:0]     tail_sum;

	logic [ID_BITS-1:0] owner_d;
	logic [NEST_W-1:0]  nest_d;
	logic [PTR_W-1:0]   head_d;
	logic [FILL_W-1:0]  fill_d;
	status_t            status_d;
	logic [ID_BITS-1:0] woken_d;

	logic [ID_BITS+OUT_ID_W-1:0] woken_ext;
	logic [ID_BITS+OUT_ID_W-1:0] owner_ext;
	logic [REQ_W+ID_BITS-1:0]    req_ext;

	assign s_axis_tready = !valid_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign done_s1       = valid_s1 && (!out_valid_q || m_axis_tready);

	assign req_ext = {{ID_BITS{1'b0}}, s_axis_tdata[OP_W +: REQ_W]};
	assign who_in  = req_ext[ID_BITS-1:0];

	assign tail_sum = {1'b0, head_q} + (PTR_W + 1)'(fill_q);
	assign tail_ptr = (tail_sum >= (PTR_W + 1)'(WAIT_DEPTH)) ?
		PTR_W'(tail_sum - (PTR_W + 1)'(WAIT_DEPTH)) : tail_sum[PTR_W-1:0];

	rlwq_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(WAIT_DEPTH)
	) u_waiters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_ptr),
		.wdata(who_s1),
		.raddr(head_q),
		.rdata(head_id)
	);

	always_comb begin
		owner_d  = owner_q;
		nest_d   = nest_q;
		head_d   = head_q;
		fill_d   = fill_q;
		status_d = ST_REFUSED;
		woken_d  = NO_ID;
		ram_we   = 1'b0;
		case (op_s1)
			OP_OBTAIN: begin
				if (who_s1 == NO_ID || who_s1 == ANON_ID) begin
					status_d = ST_REFUSED;
				end else if (nest_q == '0) begin
					owner_d  = who_s1;
					nest_d   = NEST_W'(1);
					status_d = ST_GRANTED;
				end else if (owner_q == who_s1) begin
					if (nest_q >= NEST_W'(NEST_MAX)) begin
						status_d = ST_OVERFLOW;
					end else begin
						nest_d   = nest_q + NEST_W'(1);
						status_d = ST_GRANTED;
					end
				end else if (fill_q >= FILL_W'(WAIT_DEPTH)) begin
					status_d = ST_OVERFLOW;
				end else begin
					ram_we   = done_s1;
					fill_d   = fill_q + FILL_W'(1);
					status_d = ST_QUEUED;
				end
			end
			OP_RELEASE: begin
				if (nest_q == '0) begin
					status_d = ST_CORRUPT;
				end else if (nest_q != NEST_W'(1)) begin
					nest_d   = nest_q - NEST_W'(1);
					status_d = ST_HELD;
				end else if (fill_q != '0) begin
					owner_d  = head_id;
					woken_d  = head_id;
					head_d   = (head_q == PTR_W'(WAIT_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
					fill_d   = fill_q - FILL_W'(1);
					status_d = ST_HANDED;
				end else begin
					owner_d  = NO_ID;
					nest_d   = '0;
					status_d = ST_FREED;
				end
			end
			OP_ATTEMPT: begin
				if (nest_q == '0) begin
					owner_d  = ANON_ID;
					nest_d   = NEST_W'(1);
					status_d = ST_GRANTED;
				end
			end
			default: begin
				status_d = ST_REFUSED;
			end
		endcase
	end

	assign woken_ext = {{OUT_ID_W{1'b0}}, woken_d};
	assign owner_ext = {{OUT_ID_W{1'b0}}, owner_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			owner_q     <= NO_ID;
			nest_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				out_valid_q <= 1'b1;
				owner_q     <= owner_d;
				nest_q      <= nest_d;
				head_q      <= head_d;
				fill_q      <= fill_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= s_axis_tdata[OP_W-1:0];
			who_s1 <= who_in;
		end
		if (done_s1) begin
			out_data_q <= {5'd0, owner_ext[OUT_ID_W-1:0], woken_ext[OUT_ID_W-1:0],
				status_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WAIT_DEPTH))
		else $error("waiter count beyond queue depth");

	a_free_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q == '0 |-> owner_q == NO_ID)
		else $error("free lock keeps an owner");

	a_queue_needs_owner: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != '0 |-> nest_q != '0)
		else $error("waiters queued on a free lock");

	a_woken_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[2:0] == ST_HANDED) ==
			(m_axis_tdata[10:3] != 8'd0)))
		else $error("woken identity disagrees with status");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 |=> !valid_s1 || $past(in_fire))
		else $error("request left in stage after completion");

endmodule
